// ----- sv/wmm_pkg.sv -----
package wmm_pkg;

	// Input command codes
	localparam logic [1:0] CMD_CLEAR  = 2'd0;
	localparam logic [1:0] CMD_APPEND = 2'd1;
	localparam logic [1:0] CMD_NAME   = 2'd2;
	localparam logic [1:0] CMD_END    = 2'd3;

	// Characters with a meaning of their own in a mask
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_QUEST  = 8'h3F;
	localparam logic [7:0] CH_BAR    = 8'h7C;
	localparam logic [7:0] CASE_MASK = 8'hDF;
	localparam logic [7:0] CH_NUL    = 8'h00;

	// Queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;

	typedef enum logic [1:0] {
		OP_CLEAR,
		OP_APPEND,
		OP_NAME,
		OP_END
	} op_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] ch;
	} in_item_t;

	typedef struct packed {
		logic matched;
		logic mask_truncated;
	} out_item_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] ch;
	} q_item_t;

endpackage

// ----- sv/wildcard_mask_match_top.sv -----
// Wildcard mask matcher. Load a mask one character at a time (cmd 1), stream
// a name one character per transfer (cmd 2) and close it with cmd 3, which
// returns one result: matched, and mask_truncated if mask characters beyond
// MASK_LEN were dropped since the last clear (cmd 0). '*' matches any run,
// '?' one character, other characters compare with bit 5 ignored; a mask
// that opens with '|' is a list of submasks. All mask positions step in
// parallel on a name character and runs of '*' close through a single
// carry chain, so the matcher accepts one item per cycle unless an end of
// name finds the last result still held. An item passes an input register
// and a four-entry queue before the matcher, and the result of an end of
// name appears in the output register the cycle after the matcher takes it.
// The queue lets the input keep streaming while a result waits to be taken.
module wildcard_mask_match_top #(
	parameter int MASK_LEN = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  wmm_pkg::in_item_t  item,
	output logic               result_valid,
	input  logic               result_stall,
	output wmm_pkg::out_item_t result
);

	logic             push;
	wmm_pkg::q_item_t push_data;
	logic             q_full;
	logic             pop;
	logic             q_valid;
	wmm_pkg::q_item_t q_data;

	wmm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.push       (push),
		.push_data  (push_data),
		.q_full     (q_full)
	);

	wmm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.q_valid   (q_valid),
		.q_data    (q_data)
	);

	wmm_back #(
		.MASK_LEN (MASK_LEN)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_data       (q_data),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

// ----- sv/wmm_front.sv -----
module wmm_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  wmm_pkg::in_item_t item,
	output logic              push,
	output wmm_pkg::q_item_t  push_data,
	input  logic              q_full
);

	logic             vld_s1;
	wmm_pkg::q_item_t item_s1;
	logic             accept;
	logic             keep;
	wmm_pkg::op_t     op;

	assign item_stall = vld_s1 && q_full;
	assign accept     = item_valid && !item_stall;
	assign push       = vld_s1 && !q_full;
	assign push_data  = item_s1;

	// Classify the command; drop characters that are zero bytes
	always_comb begin
		unique case (item.cmd)
			wmm_pkg::CMD_CLEAR:  op = wmm_pkg::OP_CLEAR;
			wmm_pkg::CMD_APPEND: op = wmm_pkg::OP_APPEND;
			wmm_pkg::CMD_NAME:   op = wmm_pkg::OP_NAME;
			default:             op = wmm_pkg::OP_END;
		endcase
		keep = (op == wmm_pkg::OP_CLEAR) || (op == wmm_pkg::OP_END) ||
			(item.ch != wmm_pkg::CH_NUL);
	end

	// Hold the classified item until the queue takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= keep;
		end else if (push) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.op <= op;
			item_s1.ch <= item.ch;
		end
	end

endmodule

// ----- sv/wmm_queue.sv -----
module wmm_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  wmm_pkg::q_item_t push_data,
	output logic             full,
	input  logic             pop,
	output logic             q_valid,
	output wmm_pkg::q_item_t q_data
);

	wmm_pkg::q_item_t              entries_q [wmm_pkg::QUEUE_DEPTH];
	logic [wmm_pkg::QPTR_W-1:0]    wr_q;
	logic [wmm_pkg::QPTR_W-1:0]    rd_q;
	logic [wmm_pkg::QCNT_W-1:0]    cnt_q;

	assign full    = (cnt_q == wmm_pkg::QCNT_W'(wmm_pkg::QUEUE_DEPTH));
	assign q_valid = (cnt_q != '0);
	assign q_data  = entries_q[rd_q];

	// Advance pointers and count on each transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_q] <= push_data;
		end
	end

`ifndef NO_ASSERTIONS
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (cnt_q != '0))
		else $error("queue popped while empty");
`endif

endmodule

// ----- sv/wmm_back.sv -----
module wmm_back #(
	parameter int MASK_LEN = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  wmm_pkg::q_item_t   q_data,
	output logic               pop,
	output logic               result_valid,
	input  logic               result_stall,
	output wmm_pkg::out_item_t result
);

	logic [7:0]          chars_q [MASK_LEN];
	logic [MASK_LEN-1:0] vld_q;
	logic                ovf_q;
	logic [MASK_LEN:0]   act_q;
	logic                res_vld_q;
	wmm_pkg::out_item_t  res_q;

	logic                do_clear;
	logic                do_append;
	logic                do_end;
	logic [MASK_LEN:0]   vld_ext;
	logic [MASK_LEN-1:0] we;
	logic [MASK_LEN-1:0] vld_n;
	logic [MASK_LEN-1:0] star_n;
	logic [MASK_LEN-1:0] bar_n;
	logic [MASK_LEN:0]   bar_prev_n;
	logic                list_n;
	logic [MASK_LEN:0]   seeds_list;
	logic [MASK_LEN:0]   seeds_plain;
	logic [MASK_LEN:0]   prop;
	logic                list_c;
	logic [MASK_LEN:0]   end_c;
	logic [MASK_LEN:0]   stay;
	logic [MASK_LEN-1:0] adv;
	logic [MASK_LEN:0]   nxt;
	logic [MASK_LEN:0]   seed;
	logic [MASK_LEN:0]   closure;
	logic                accepting;
	logic [7:0]          ch_n;

	// Take the next queued item unless an end of name finds the result held
	assign pop       = q_valid && ((q_data.op != wmm_pkg::OP_END) || !res_vld_q ||
		!result_stall);
	assign do_clear  = pop && (q_data.op == wmm_pkg::OP_CLEAR);
	assign do_append = pop && (q_data.op == wmm_pkg::OP_APPEND);
	assign do_end    = pop && (q_data.op == wmm_pkg::OP_END);

	assign result_valid = res_vld_q;
	assign result       = res_q;

	// Mask as it stands after this item
	assign vld_ext = {vld_q, 1'b1};
	always_comb begin
		for (int p = 0; p < MASK_LEN; p++) begin
			we[p]     = do_append && !vld_q[p] && vld_ext[p];
			ch_n      = we[p] ? q_data.ch : chars_q[p];
			star_n[p] = (ch_n == wmm_pkg::CH_STAR);
			bar_n[p]  = (ch_n == wmm_pkg::CH_BAR);
		end
		vld_n = do_clear ? '0 : (vld_q | we);
	end

	// Start positions of the new mask and star propagation
	assign list_n      = vld_n[0] && bar_n[0];
	assign bar_prev_n  = {bar_n, 1'b0};
	assign seeds_list  = {1'b0, vld_n & bar_prev_n[MASK_LEN-1:0]};
	assign seeds_plain = {{MASK_LEN{1'b0}}, 1'b1};
	assign prop        = {1'b0, vld_n & star_n};

	// Submask ends of the current mask
	assign list_c = vld_q[0] && (chars_q[0] == wmm_pkg::CH_BAR);
	always_comb begin
		end_c[MASK_LEN] = 1'b1;
		for (int p = 0; p < MASK_LEN; p++) begin
			end_c[p] = !vld_q[p] ||
				(list_c && (p > 0) && (chars_q[p] == wmm_pkg::CH_BAR));
		end
	end

	// Step every active position on one name character
	always_comb begin
		stay[MASK_LEN] = 1'b0;
		for (int p = 0; p < MASK_LEN; p++) begin
			stay[p] = 1'b0;
			adv[p]  = 1'b0;
			if (act_q[p] && !end_c[p]) begin
				if (chars_q[p] == wmm_pkg::CH_STAR) begin
					stay[p] = 1'b1;
				end else if ((chars_q[p] == wmm_pkg::CH_QUEST) ||
					(((chars_q[p] ^ q_data.ch) & wmm_pkg::CASE_MASK) == 8'h00)) begin
					adv[p] = 1'b1;
				end
			end
		end
		nxt = stay | {adv, 1'b0};
	end

	// Close over runs of stars with one carry chain
	always_comb begin
		if (q_data.op == wmm_pkg::OP_NAME) begin
			seed = nxt;
		end else if (list_n) begin
			seed = seeds_list;
		end else begin
			seed = seeds_plain;
		end
		closure = seed | (((seed & prop) + prop) ^ prop);
	end

	assign accepting = |(act_q & end_c);

	// Update mask state, active set and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			ovf_q     <= 1'b0;
			act_q     <= {{MASK_LEN{1'b0}}, 1'b1};
			res_vld_q <= 1'b0;
		end else begin
			if (pop) begin
				vld_q <= vld_n;
				act_q <= closure;
			end
			if (do_clear) begin
				ovf_q <= 1'b0;
			end else if (do_append && vld_q[MASK_LEN-1]) begin
				ovf_q <= 1'b1;
			end
			if (do_end) begin
				res_vld_q <= 1'b1;
			end else if (!result_stall) begin
				res_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int p = 0; p < MASK_LEN; p++) begin
			if (we[p]) begin
				chars_q[p] <= q_data.ch;
			end
		end
		if (do_end) begin
			res_q.matched        <= accepting;
			res_q.mask_truncated <= ovf_q;
		end
	end

`ifndef NO_ASSERTIONS
	a_ovf_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ovf_q) |-> $past(do_append && vld_q[MASK_LEN-1]))
		else $error("overflow set without an append to a full mask");

	a_result_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_vld_q) |-> $past(do_end))
		else $error("result raised without an end of name");

	a_active_in_mask: assert property (@(posedge clk) disable iff (!arst_n)
		(act_q[MASK_LEN:1] & ~vld_q) == '0)
		else $error("active position beyond the stored mask");
`endif

endmodule
